@@ rtl/lnpa_pkg.sv @@
// Shared constants, request and status codes and the sequencer state type
// for the linked node pool allocator. No dependencies.
package lnpa_pkg;

  localparam int REQ_W      = 3;
  localparam int CNT_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int KEY_PORT_W = 16;
  localparam int VALUE_W    = 32;
  localparam int KEY_FIELDS = 4;
  localparam int KEY_IDX_W  = 2;
  localparam int MAX_FIELDS = 4;
  localparam int CNT_LIMIT  = (MAX_FIELDS < KEY_FIELDS) ? MAX_FIELDS : KEY_FIELDS;

  localparam logic [REQ_W-1:0] REQ_ALLOC = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PUT   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_GET   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PROBE = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO      = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_ALLOC,
    S_FREE,
    S_FIND,
    S_COUNT_GO,
    S_COUNT,
    S_DONE
  } state_t;

endpackage

@@ rtl/lnpa_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module lnpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lnpa_ctrl.sv @@
// Request sequencer for the linked node pool allocator: decodes a request,
// walks chains and the free list through the node and value RAMs.
// Depends on lnpa_pkg.
module lnpa_ctrl #(
  parameter int MEM_NODES = 64,
  parameter int KEY_BITS  = 16,
  localparam int ADDR_W = $clog2(MEM_NODES),
  localparam int LINK_W = $clog2(MEM_NODES + 1),
  localparam int KEY_W  = (KEY_BITS < lnpa_pkg::KEY_PORT_W) ? KEY_BITS : lnpa_pkg::KEY_PORT_W,
  localparam int NODE_W = LINK_W + KEY_W
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lnpa_pkg::REQ_W-1:0]      req_type,
  input  logic [ADDR_W-1:0]               address,
  input  logic [lnpa_pkg::CNT_W-1:0]      field_count,
  input  logic [lnpa_pkg::KEY_PORT_W-1:0] key_0,
  input  logic [lnpa_pkg::KEY_PORT_W-1:0] key_1,
  input  logic [lnpa_pkg::KEY_PORT_W-1:0] key_2,
  input  logic [lnpa_pkg::KEY_PORT_W-1:0] key_3,
  input  logic [lnpa_pkg::KEY_PORT_W-1:0] search_key,
  input  logic signed [lnpa_pkg::VALUE_W-1:0] value_in,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic [lnpa_pkg::STATUS_W-1:0]   res_status,
  output logic [ADDR_W-1:0]               res_head,
  output logic signed [lnpa_pkg::VALUE_W-1:0] res_value,
  output logic                            res_occupied,
  output logic [LINK_W-1:0]               res_free,
  output logic                            node_we,
  output logic [ADDR_W-1:0]               node_waddr,
  output logic [NODE_W-1:0]               node_wdata,
  output logic [ADDR_W-1:0]               node_raddr,
  input  logic [NODE_W-1:0]               node_rdata,
  output logic                            val_we,
  output logic [ADDR_W-1:0]               val_waddr,
  output logic [lnpa_pkg::VALUE_W-1:0]    val_wdata,
  output logic [ADDR_W-1:0]               val_raddr,
  input  logic [lnpa_pkg::VALUE_W-1:0]    val_rdata
);

  import lnpa_pkg::*;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MEM_NODES);

  state_t state, state_next;

  logic [REQ_W-1:0]     req_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [KEY_W-1:0]     keys_q [KEY_FIELDS];
  logic [KEY_W-1:0]     skey_q;
  logic [VALUE_W-1:0]   value_q;
  logic [LINK_W-1:0]    cur;
  logic [LINK_W-1:0]    steps;
  logic [KEY_IDX_W-1:0] idx;
  logic [LINK_W-1:0]    free_head;
  logic [LINK_W-1:0]    free_total;
  logic [ADDR_W-1:0]    clr;
  logic [STATUS_W-1:0]  status_q;
  logic [ADDR_W-1:0]    head_q;
  logic [VALUE_W-1:0]   vout_q;
  logic                 occ_q;

  logic [LINK_W-1:0] link_rd;
  logic [KEY_W-1:0]  key_rd;
  logic              link_null;
  logic              head_null;
  logic              addr_ok;
  logic [LINK_W-1:0] steps_inc;
  logic              walk_limit;
  logic              alloc_zero;
  logic              alloc_bad;
  logic              alloc_last;
  logic              key_match;
  logic              probe_hit;

  assign link_rd    = node_rdata[NODE_W-1:KEY_W];
  assign key_rd     = node_rdata[KEY_W-1:0];
  assign link_null  = (link_rd >= NULL_LINK);
  assign head_null  = (free_head >= NULL_LINK);
  assign addr_ok    = (LINK_W'(addr_q) < NULL_LINK);
  assign steps_inc  = steps + LINK_W'(1);
  assign walk_limit = (steps_inc == NULL_LINK);
  assign alloc_zero = (cnt_q == '0);
  assign alloc_bad  = (cnt_q > CNT_W'(CNT_LIMIT)) ||
                      ({{LINK_W{1'b0}}, cnt_q} > {{CNT_W{1'b0}}, free_total});
  assign alloc_last = (CNT_W'(idx) == cnt_q - CNT_W'(1));
  assign key_match  = (key_rd == skey_q);
  assign probe_hit  = (req_q == REQ_PROBE) && (cur == LINK_W'(addr_q));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr == ADDR_W'(MEM_NODES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (req_q)
          REQ_ALLOC: state_next = (alloc_zero || alloc_bad) ? S_DONE : S_ALLOC;
          REQ_FREE:  state_next = addr_ok ? S_FREE : S_DONE;
          REQ_PUT, REQ_GET: state_next = addr_ok ? S_FIND : S_DONE;
          REQ_PROBE: state_next = (addr_ok && !head_null) ? S_COUNT : S_DONE;
          default:   state_next = S_DONE;
        endcase
      end
      S_ALLOC: begin
        if (alloc_last) begin
          state_next = S_COUNT_GO;
        end
      end
      S_FREE: begin
        if (link_null) begin
          state_next = S_COUNT_GO;
        end else if (steps == NULL_LINK) begin
          state_next = S_DONE;
        end
      end
      S_FIND: begin
        if (key_match || link_null || walk_limit) begin
          state_next = S_DONE;
        end
      end
      S_COUNT_GO: begin
        state_next = head_null ? S_DONE : S_COUNT;
      end
      S_COUNT: begin
        if (probe_hit || link_null || walk_limit) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory ports and handshake outputs.
  always_comb begin
    node_we    = 1'b0;
    node_waddr = cur[ADDR_W-1:0];
    node_wdata = {link_rd, key_rd};
    node_raddr = link_rd[ADDR_W-1:0];
    val_we     = 1'b0;
    unique case (state)
      S_CLEAR: begin
        node_we    = 1'b1;
        node_waddr = clr;
        node_wdata = {LINK_W'(clr) + LINK_W'(1), {KEY_W{1'b0}}};
      end
      S_DECODE: begin
        node_raddr = (req_q == REQ_ALLOC || req_q == REQ_PROBE) ?
                     free_head[ADDR_W-1:0] : addr_q;
      end
      S_ALLOC: begin
        node_we    = 1'b1;
        node_wdata = {alloc_last ? NULL_LINK : link_rd, keys_q[idx]};
      end
      S_FREE: begin
        node_we    = link_null;
        node_wdata = {free_head, key_rd};
      end
      S_FIND: begin
        val_we = key_match && (req_q == REQ_PUT);
      end
      S_COUNT_GO: begin
        node_raddr = free_head[ADDR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  assign val_raddr    = node_raddr;
  assign val_waddr    = cur[ADDR_W-1:0];
  assign val_wdata    = value_q;
  assign in_ready     = (state == S_IDLE);
  assign res_valid    = (state == S_DONE);
  assign res_status   = status_q;
  assign res_head     = head_q;
  assign res_value    = vout_q;
  assign res_occupied = occ_q;
  assign res_free     = free_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr        <= '0;
      free_head  <= '0;
      free_total <= NULL_LINK;
    end else begin
      state <= state_next;
      case (state)
        S_CLEAR: begin
          clr <= clr + ADDR_W'(1);
        end
        S_IDLE: begin
          if (in_valid) begin
            req_q     <= req_type;
            addr_q    <= address;
            cnt_q     <= field_count;
            keys_q[0] <= key_0[KEY_W-1:0];
            keys_q[1] <= key_1[KEY_W-1:0];
            keys_q[2] <= key_2[KEY_W-1:0];
            keys_q[3] <= key_3[KEY_W-1:0];
            skey_q    <= search_key[KEY_W-1:0];
            value_q   <= value_in;
          end
        end
        S_DECODE: begin
          status_q <= ST_OK;
          head_q   <= '0;
          vout_q   <= '0;
          occ_q    <= 1'b0;
          steps    <= '0;
          idx      <= '0;
          cur      <= (req_q == REQ_ALLOC || req_q == REQ_PROBE) ?
                      free_head : LINK_W'(addr_q);
          case (req_q)
            REQ_ALLOC: begin
              if (alloc_zero) begin
                status_q <= ST_ZERO;
              end else if (alloc_bad) begin
                status_q <= ST_SHORT;
              end else begin
                head_q <= free_head[ADDR_W-1:0];
              end
            end
            REQ_PUT, REQ_GET: begin
              if (!addr_ok) begin
                status_q <= ST_NOT_FOUND;
              end
            end
            REQ_PROBE: begin
              if (!addr_ok || head_null) begin
                occ_q <= 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        S_ALLOC: begin
          if (alloc_last) begin
            free_head <= link_rd;
          end else begin
            cur <= link_rd;
            idx <= idx + KEY_IDX_W'(1);
          end
        end
        S_FREE: begin
          if (link_null) begin
            free_head <= LINK_W'(addr_q);
          end else if (steps != NULL_LINK) begin
            cur   <= link_rd;
            steps <= steps_inc;
          end
        end
        S_FIND: begin
          if (key_match) begin
            if (req_q == REQ_GET) begin
              vout_q <= val_rdata;
            end
          end else if (link_null || walk_limit) begin
            status_q <= ST_NOT_FOUND;
          end else begin
            cur   <= link_rd;
            steps <= steps_inc;
          end
        end
        S_COUNT_GO: begin
          cur   <= free_head;
          steps <= '0;
          if (head_null) begin
            free_total <= '0;
          end
        end
        S_COUNT: begin
          if (!probe_hit) begin
            if (link_null || walk_limit) begin
              free_total <= steps_inc;
              if (req_q == REQ_PROBE) begin
                occ_q <= 1'b1;
              end
            end else begin
              cur   <= link_rd;
              steps <= steps_inc;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The free count can never exceed the pool, whatever shape the links take.
  a_free_bounded: assert property (@(posedge clk) disable iff (rst)
    free_total <= NULL_LINK)
    else $error("free node count exceeds the pool size");

  // Walk step counters stay within one pass over the pool.
  a_steps_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_FREE || state == S_FIND || state == S_COUNT) |-> steps <= NULL_LINK)
    else $error("walk ran beyond the pool size");

  // No memory is written while a result is on offer or the block is idle.
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !node_we && !val_we)
    else $error("memory write outside a request");

  // An accepted word is decoded in the very next cycle.
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_DECODE)
    else $error("accepted word not decoded");

  // A successful allocate hands out the head that the free list had.
  a_alloc_head: assert property (@(posedge clk) disable iff (rst)
    state == S_DECODE && req_q == REQ_ALLOC && !alloc_zero && !alloc_bad
    |=> head_q == $past(free_head[ADDR_W-1:0]))
    else $error("allocated head differs from the free head");

endmodule

@@ rtl/linked_node_pool_allocator.sv @@
// Top level of the linked node pool allocator: node and value RAMs, the
// request sequencer and the result register. Depends on lnpa_pkg, lnpa_ram
// and lnpa_ctrl.
//
// The block manages a pool of MEM_NODES nodes, each holding a link, a key and
// a 32-bit value, with the free nodes threaded into a list through the links.
// After reset it sweeps the link RAM into one free list and takes no word
// until that sweep is over. One request is in work at a time; every request
// gives exactly one result word, and the result register lets a new request
// be taken while the previous result waits. Each request passes through
// decode and hand-off plus the walk it needs, which reads one node per cycle
// from the node RAM: an allocate walks field_count free nodes, a free walks
// every node of the chain, put and get walk up to the matching key, and
// probe walks the free list up to the probed address. Allocate and free then
// recount the free list, walking every free node.
module linked_node_pool_allocator #(
  parameter int MEM_NODES = 64,
  parameter int KEY_BITS  = 16,
  localparam int ADDR_W = $clog2(MEM_NODES),
  localparam int LINK_W = $clog2(MEM_NODES + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lnpa_pkg::REQ_W-1:0]      req_type,
  input  logic [ADDR_W-1:0]               address,
  input  logic [lnpa_pkg::CNT_W-1:0]      field_count,
  input  logic [lnpa_pkg::KEY_PORT_W-1:0] key_0,
  input  logic [lnpa_pkg::KEY_PORT_W-1:0] key_1,
  input  logic [lnpa_pkg::KEY_PORT_W-1:0] key_2,
  input  logic [lnpa_pkg::KEY_PORT_W-1:0] key_3,
  input  logic [lnpa_pkg::KEY_PORT_W-1:0] search_key,
  input  logic signed [lnpa_pkg::VALUE_W-1:0] value_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lnpa_pkg::STATUS_W-1:0]   status,
  output logic [ADDR_W-1:0]               head_address,
  output logic signed [lnpa_pkg::VALUE_W-1:0] value_out,
  output logic                            occupied,
  output logic [LINK_W-1:0]               free_nodes
);

  import lnpa_pkg::*;

  // Keys are held at the narrower of the port width and KEY_BITS.
  localparam int KEY_W  = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
  localparam int NODE_W = LINK_W + KEY_W;

  logic                 res_valid;
  logic                 res_ready;
  logic [STATUS_W-1:0]  res_status;
  logic [ADDR_W-1:0]    res_head;
  logic signed [VALUE_W-1:0] res_value;
  logic                 res_occupied;
  logic [LINK_W-1:0]    res_free;

  logic                 node_we;
  logic [ADDR_W-1:0]    node_waddr;
  logic [NODE_W-1:0]    node_wdata;
  logic [ADDR_W-1:0]    node_raddr;
  logic [NODE_W-1:0]    node_rdata;
  logic                 val_we;
  logic [ADDR_W-1:0]    val_waddr;
  logic [VALUE_W-1:0]   val_wdata;
  logic [ADDR_W-1:0]    val_raddr;
  logic [VALUE_W-1:0]   val_rdata;

  // Node RAM: each word is the link in the upper bits and the key below it.
  lnpa_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MEM_NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  // Value RAM: read alongside the node RAM so that a get finds the value of
  // the matching node in the same cycle as its key.
  lnpa_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MEM_NODES)
  ) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  lnpa_ctrl #(
    .MEM_NODES (MEM_NODES),
    .KEY_BITS  (KEY_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .address      (address),
    .field_count  (field_count),
    .key_0        (key_0),
    .key_1        (key_1),
    .key_2        (key_2),
    .key_3        (key_3),
    .search_key   (search_key),
    .value_in     (value_in),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_status   (res_status),
    .res_head     (res_head),
    .res_value    (res_value),
    .res_occupied (res_occupied),
    .res_free     (res_free),
    .node_we      (node_we),
    .node_waddr   (node_waddr),
    .node_wdata   (node_wdata),
    .node_raddr   (node_raddr),
    .node_rdata   (node_rdata),
    .val_we       (val_we),
    .val_waddr    (val_waddr),
    .val_wdata    (val_wdata),
    .val_raddr    (val_raddr),
    .val_rdata    (val_rdata)
  );

  // Result register. The sequencer hands over a result word whenever the
  // register is empty or is being emptied in the same cycle.
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status       <= res_status;
      head_address <= res_head;
      value_out    <= res_value;
      occupied     <= res_occupied;
      free_nodes   <= res_free;
    end
  end

endmodule
